### rtl/shifted_rectangle_blit_assert.svh
// Assertion macros shared by the rectangle blitter RTL.
// Users must have clk and rst (synchronous, active high) in scope.
`ifndef SHIFTED_RECTANGLE_BLIT_ASSERT_SVH
`define SHIFTED_RECTANGLE_BLIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/srb_pkg.sv
// Package for the shifted rectangle blitter: mode codes, register indexes
// and fixed widths. No dependencies.
package srb_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int SHIFT_BITS     = 3;
  localparam int PITCH_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [BYTE_BITS-1:0] FILL_BYTE = '1;

  typedef enum logic [1:0] {
    MODE_SHL_DESC   = 2'd0,
    MODE_SHR_ASC    = 2'd1,
    MODE_ALIGN_ASC  = 2'd2,
    MODE_ALIGN_DESC = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE         = 3'd0,
    REG_SHIFT_AMOUNT = 3'd1,
    REG_DEST_START   = 3'd2,
    REG_BYTE_WIDTH   = 3'd3,
    REG_ROW_COUNT    = 3'd4,
    REG_ROW_PITCH    = 3'd5
  } reg_index_t;

  localparam mode_t                  MODE_RESET  = MODE_SHR_ASC;
  localparam logic [SHIFT_BITS-1:0]  SHIFT_RESET = 3'd1;
  localparam logic [PITCH_BITS-1:0]  PITCH_RESET = 16'd80;

endpackage

### rtl/shifted_rectangle_blit.sv
// Shifted rectangle blitter: one source byte per request in, one write per non-priming byte.
// Depends on srb_pkg and shifted_rectangle_blit_assert.svh.
// A write reaches m_tvalid from the result register, via the skid entry if the output stalls.
// Throughput: one request per cycle while skid is empty; set by the carry/counter update loop.
// A two-entry output (result register plus skid) keeps s_tready up while one write waits.
// Reset (rst, synchronous): registers to defaults, walk restarted, output queue emptied.
`include "shifted_rectangle_blit_assert.svh"

module shifted_rectangle_blit #(
  parameter int ADDRESS_BITS = 16,
  parameter int COUNT_BITS   = 12,
  localparam int CFG_DATA_BITS = (ADDRESS_BITS > 16) ? ADDRESS_BITS : 16,
  localparam int TDATA_BITS    = ((ADDRESS_BITS + 8 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [srb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_data,
  // source byte requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [srb_pkg::BYTE_BITS-1:0]     s_tdata,   // [7:0] source_byte
  // destination writes
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [TDATA_BITS-1:0]             m_tdata,   // write_address, then write_data, zero pad
  output logic                              m_tlast,   // row_last
  output logic                              m_tuser    // block_last
);

  import srb_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mode_t                   mode;
  logic [SHIFT_BITS-1:0]   shift_amount;
  logic [ADDRESS_BITS-1:0] dest_start;
  logic [COUNT_BITS-1:0]   byte_width;
  logic [COUNT_BITS-1:0]   row_count;
  logic signed [PITCH_BITS-1:0] row_pitch;

  // ---------------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------------
  logic [BYTE_BITS-1:0]    carry_bits;
  logic [COUNT_BITS-1:0]   column_count;
  logic [COUNT_BITS-1:0]   rows_left;
  logic [ADDRESS_BITS-1:0] row_start_address;
  logic [ADDRESS_BITS-1:0] current_address;
  logic                    priming_pending;

  // Output queue: result register (out_*) plus one skid entry (skid_*).
  logic                    out_valid;
  logic [ADDRESS_BITS-1:0] out_addr;
  logic [BYTE_BITS-1:0]    out_data;
  logic                    out_row_last;
  logic                    out_block_last;
  logic                    skid_valid;
  logic [ADDRESS_BITS-1:0] skid_addr;
  logic [BYTE_BITS-1:0]    skid_data;
  logic                    skid_row_last;
  logic                    skid_block_last;

  // ---------------------------------------------------------------------------
  // Per-request datapath
  // ---------------------------------------------------------------------------
  logic                    accept;
  logic                    shift_mode;
  logic                    descending;
  logic                    priming;
  logic [3:0]              back_shift;
  logic [BYTE_BITS-1:0]    byte_shr;
  logic [BYTE_BITS-1:0]    byte_shl;
  logic [BYTE_BITS-1:0]    new_carry;
  logic [BYTE_BITS-1:0]    write_data;
  logic [COUNT_BITS-1:0]   column_next;
  logic                    row_end;
  logic                    block_end;
  logic [ADDRESS_BITS-1:0] addr_step;
  logic [ADDRESS_BITS-1:0] pitch_ext;
  logic [ADDRESS_BITS-1:0] row_start_next;
  logic                    res_valid;
  logic                    drain;

  assign s_tready   = !skid_valid;
  assign accept     = s_tvalid && s_tready;

  assign shift_mode = (mode == MODE_SHL_DESC) || (mode == MODE_SHR_ASC);
  assign descending = (mode == MODE_SHL_DESC) || (mode == MODE_ALIGN_DESC);
  assign priming    = shift_mode && priming_pending;

  // Back shift runs 1..8; a shift by 8 on a byte yields zero.
  assign back_shift = 4'd8 - {1'b0, shift_amount};
  assign byte_shr   = s_tdata >> shift_amount;
  assign byte_shl   = s_tdata << back_shift;

  // Right shift ascending writes the right-shifted byte and carries the
  // spilled low bits up; left shift descending is the mirror image.
  always_comb begin
    case (mode)
      MODE_SHR_ASC: begin
        write_data = byte_shr | carry_bits;
        new_carry  = byte_shl;
      end
      MODE_SHL_DESC: begin
        write_data = byte_shl | carry_bits;
        new_carry  = byte_shr;
      end
      default: begin
        write_data = FILL_BYTE;
        new_carry  = carry_bits;
      end
    endcase
  end

  assign column_next    = column_count + COUNT_BITS'(1);
  assign row_end        = (column_next == byte_width);
  assign block_end      = row_end && (rows_left == COUNT_BITS'(1));
  assign addr_step      = descending ? current_address - ADDRESS_BITS'(1)
                                     : current_address + ADDRESS_BITS'(1);
  // Sign-extend (or truncate) the pitch to the address width.
  assign pitch_ext      = ADDRESS_BITS'(row_pitch);
  assign row_start_next = row_start_address + pitch_ext;

  assign res_valid = accept && !priming;
  assign drain     = !out_valid || m_tready;

  // ---------------------------------------------------------------------------
  // Configuration and walk state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_RESET;
      shift_amount      <= SHIFT_RESET;
      dest_start        <= '0;
      byte_width        <= COUNT_BITS'(1);
      row_count         <= COUNT_BITS'(1);
      row_pitch         <= PITCH_RESET;
      carry_bits        <= '0;
      column_count      <= '0;
      rows_left         <= COUNT_BITS'(1);
      row_start_address <= '0;
      current_address   <= '0;
      priming_pending   <= 1'b1;
    end else if (cfg_write) begin
      // Store the register and restart the walk; unknown indexes are dropped.
      case (cfg_index)
        REG_MODE: begin
          mode              <= mode_t'(cfg_data[1:0]);
          priming_pending   <= !cfg_data[1];
          rows_left         <= row_count;
          row_start_address <= dest_start;
          current_address   <= dest_start;
          carry_bits        <= '0;
          column_count      <= '0;
        end
        REG_SHIFT_AMOUNT, REG_BYTE_WIDTH, REG_ROW_PITCH: begin
          if (cfg_index == REG_SHIFT_AMOUNT) shift_amount <= cfg_data[SHIFT_BITS-1:0];
          if (cfg_index == REG_BYTE_WIDTH)   byte_width   <= cfg_data[COUNT_BITS-1:0];
          if (cfg_index == REG_ROW_PITCH)    row_pitch    <= cfg_data[PITCH_BITS-1:0];
          priming_pending   <= shift_mode;
          rows_left         <= row_count;
          row_start_address <= dest_start;
          current_address   <= dest_start;
          carry_bits        <= '0;
          column_count      <= '0;
        end
        REG_DEST_START: begin
          dest_start        <= cfg_data[ADDRESS_BITS-1:0];
          priming_pending   <= shift_mode;
          rows_left         <= row_count;
          row_start_address <= cfg_data[ADDRESS_BITS-1:0];
          current_address   <= cfg_data[ADDRESS_BITS-1:0];
          carry_bits        <= '0;
          column_count      <= '0;
        end
        REG_ROW_COUNT: begin
          row_count         <= cfg_data[COUNT_BITS-1:0];
          priming_pending   <= shift_mode;
          rows_left         <= cfg_data[COUNT_BITS-1:0];
          row_start_address <= dest_start;
          current_address   <= dest_start;
          carry_bits        <= '0;
          column_count      <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      carry_bits <= new_carry;
      if (priming) begin
        // Priming byte only seeds the carry.
        priming_pending <= 1'b0;
      end else if (block_end) begin
        // Rectangle done: restart at the top, as after reset.
        carry_bits        <= '0;
        column_count      <= '0;
        rows_left         <= row_count;
        row_start_address <= dest_start;
        current_address   <= dest_start;
        priming_pending   <= shift_mode;
      end else if (row_end) begin
        // Advance to the next row start by the signed pitch.
        column_count      <= '0;
        rows_left         <= rows_left - COUNT_BITS'(1);
        row_start_address <= row_start_next;
        current_address   <= row_start_next;
        priming_pending   <= shift_mode;
      end else begin
        column_count    <= column_next;
        current_address <= addr_step;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: the skid entry catches a write while the result register stalls
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_addr       <= skid_addr;
        out_data       <= skid_data;
        out_row_last   <= skid_row_last;
        out_block_last <= skid_block_last;
      end else if (res_valid) begin
        out_addr       <= current_address;
        out_data       <= write_data;
        out_row_last   <= row_end;
        out_block_last <= block_end;
      end
    end else if (res_valid) begin
      skid_addr       <= current_address;
      skid_data       <= write_data;
      skid_row_last   <= row_end;
      skid_block_last <= block_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_BITS'({out_data, out_addr});
  assign m_tlast  = out_row_last;
  assign m_tuser  = out_block_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SRB_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
                  "skid entry held while result register empty")
  `SRB_ASSERT_NOW(a_block_ends_row, out_valid && out_block_last, out_row_last,
                  "block end write not marked as row end")
  `SRB_ASSERT_NEXT(a_restart_after_block, res_valid && block_end && !cfg_write,
                   (current_address == dest_start) && (rows_left == row_count)
                   && (column_count == '0),
                   "walk not restarted after last write of rectangle")
  `SRB_ASSERT_NEXT(a_aligned_keeps_carry, accept && !shift_mode && !cfg_write,
                   $stable(carry_bits),
                   "carry changed in an aligned mode")

endmodule

### sim/blit_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the shifted rectangle blitter: predicts each destination write from
// the source bytes and register writes, and compares against what the block emits.
// Depends on srb_pkg (mode codes, register indexes, reset values).
package blit_check_pkg;
  import srb_pkg::*;

  // Indexes past the register list: the block must ignore writes to them.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_0 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_1 = 3'd7;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
    logic        row_last;
    logic        block_last;
  } blit_write_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [15:0]               value;
  } reg_write_t;

  class blit_scoreboard;
    // register copies
    mode_t           mode;
    logic [2:0]      shift_amount;
    logic [15:0]     dest_start;
    logic [11:0]     byte_width;
    logic [11:0]     row_count;
    logic [15:0]     row_pitch;
    // walk state
    logic [7:0]      carry;
    logic [11:0]     column;
    logic [11:0]     rows_left;
    logic [15:0]     row_base;
    logic [15:0]     write_ptr;
    logic            priming;

    blit_write_t     pending_writes[$];
    int unsigned     mismatches = 0;

    function new();
      power_on();
    endfunction

    function bit in_shift_mode();
      return mode == MODE_SHL_DESC || mode == MODE_SHR_ASC;
    endfunction

    function void restart_walk();
      carry     = '0;
      column    = '0;
      rows_left = row_count;
      row_base  = dest_start;
      write_ptr = dest_start;
      priming   = in_shift_mode();
    endfunction

    function void power_on();
      mode         = MODE_RESET;
      shift_amount = SHIFT_RESET;
      dest_start   = '0;
      byte_width   = 12'd1;
      row_count    = 12'd1;
      row_pitch    = PITCH_RESET;
      pending_writes.delete();
      restart_walk();
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [15:0] value);
      case (index)
        REG_MODE:         mode = mode_t'(value[1:0]);
        REG_SHIFT_AMOUNT: shift_amount = value[2:0];
        REG_DEST_START:   dest_start = value;
        REG_BYTE_WIDTH:   byte_width = value[11:0];
        REG_ROW_COUNT:    row_count = value[11:0];
        REG_ROW_PITCH:    row_pitch = value;
        default:          return;
      endcase
      restart_walk();
    endfunction

    // Advance the walk by one source byte; queue the write it causes, if any.
    function void take_source_byte(logic [7:0] src);
      logic [3:0]  back_shift;
      logic [7:0]  data;
      logic [11:0] next_column;
      blit_write_t w;
      back_shift = 4'd8 - {1'b0, shift_amount};
      if (in_shift_mode() && priming) begin
        if (mode == MODE_SHR_ASC) carry = src << back_shift;
        else carry = src >> shift_amount;
        priming = 1'b0;
        return;
      end
      case (mode)
        MODE_SHR_ASC: begin
          data  = (src >> shift_amount) | carry;
          carry = src << back_shift;
        end
        MODE_SHL_DESC: begin
          data  = (src << back_shift) | carry;
          carry = src >> shift_amount;
        end
        default: data = FILL_BYTE;
      endcase
      w.address    = write_ptr;
      w.data       = data;
      w.block_last = 1'b0;
      if (mode == MODE_SHL_DESC || mode == MODE_ALIGN_DESC) write_ptr = write_ptr - 16'd1;
      else write_ptr = write_ptr + 16'd1;
      next_column = column + 12'd1;
      w.row_last  = next_column == byte_width;
      if (w.row_last) begin
        if (rows_left == 12'd1) begin
          w.block_last = 1'b1;
          restart_walk();
        end else begin
          rows_left = rows_left - 12'd1;
          row_base  = row_base + row_pitch;
          write_ptr = row_base;
          column    = '0;
          priming   = in_shift_mode();
        end
      end else begin
        column = next_column;
      end
      pending_writes.push_back(w);
    endfunction

    function void check_write(logic [15:0] address, logic [7:0] data,
                              logic row_last, logic block_last);
      blit_write_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        $error("unexpected write: write_address %h write_data %h", address, data);
        return;
      end
      want = pending_writes.pop_front();
      if (address !== want.address) begin
        mismatches++;
        $error("write_address: expected %h, got %h", want.address, address);
      end
      if (data !== want.data) begin
        mismatches++;
        $error("write_data: expected %h, got %h", want.data, data);
      end
      if (row_last !== want.row_last) begin
        mismatches++;
        $error("row_last: expected %b, got %b", want.row_last, row_last);
      end
      if (block_last !== want.block_last) begin
        mismatches++;
        $error("block_last: expected %b, got %b", want.block_last, block_last);
      end
    endfunction
  endclass

endpackage

### sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the shifted rectangle blitter bench: clock, reset, source and sink drivers.
// Depends on srb_pkg, blit_check_pkg and the shifted_rectangle_blit RTL.
module tb_top;
  import srb_pkg::*;
  import blit_check_pkg::*;

  localparam int SETTLE_CYCLES  = 4;     // idle margin after the drain
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or write taken

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] source_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [15:0] write_address, [23:16] write_data
  logic        m_tlast;        // row_last
  logic        m_tuser;        // block_last

  int unsigned    sender_gap_pct = 0;
  int unsigned    receiver_gap_pct = 0;
  int unsigned    quiet_cycles = 0;
  reg_write_t     reg_writes[$];
  blit_scoreboard sb;

  shifted_rectangle_blit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Stall the write side at random; the rate follows the current idling regime.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_gap_pct);
  end

  // Sample both handshakes and the config port at the rising edge. Take the request
  // before checking the write so a same-cycle result would still find its entry.
  always @(posedge clk) begin
    if (rst) begin
      sb.power_on();
    end else begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.take_source_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_write(m_tdata[15:0], m_tdata[23:16], m_tlast, m_tuser);
    end
  end

  // Abort when neither side has moved for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one source byte. Enter and leave at a falling edge; s_tvalid stays high on
  // return so back-to-back requests never drop it within one step.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop the request line and hold until every predicted write has come out.
  task automatic hold_for_drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending_writes.size() != 0) @(negedge clk);
  endtask

  // Bring the block to idle before a register write: drain, then cover a priming
  // byte that may still be in flight.
  task automatic settle();
    hold_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_write(input logic [2:0] index, input logic [15:0] value);
    reg_write_t w;
    w.index = index;
    w.value = value;
    reg_writes.push_back(w);
  endtask

  task automatic queue_rectangle(input mode_t m, input logic [2:0] shift,
                                 input logic [15:0] dest, input logic [11:0] width,
                                 input logic [11:0] rows, input logic [15:0] pitch);
    queue_write(REG_MODE, 16'(m));
    queue_write(REG_SHIFT_AMOUNT, {13'd0, shift});
    queue_write(REG_DEST_START, dest);
    queue_write(REG_BYTE_WIDTH, {4'd0, width});
    queue_write(REG_ROW_COUNT, {4'd0, rows});
    queue_write(REG_ROW_PITCH, pitch);
  endtask

  // Issue the queued register writes on consecutive cycles; the block must be idle.
  task automatic program_registers();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_write <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.value;
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Random rectangles with random content. Most phases program a whole setting and
  // run the walk once or twice plus a partial one; some poke a single register with
  // an unmasked value, spare indexes included.
  task automatic random_items(input int unsigned total);
    int unsigned sent;
    int unsigned walk;
    int unsigned count;
    int unsigned cols;
    int unsigned rows;
    sent = 0;
    while (sent < total) begin
      settle();
      if ($urandom_range(5) == 0) begin
        queue_write(3'($urandom_range(7)), 16'($urandom));
      end else begin
        queue_rectangle(mode_t'($urandom_range(3)), 3'($urandom_range(7)), 16'($urandom),
                        ($urandom_range(7) == 0) ? 12'($urandom_range(64, 1))
                                                 : 12'($urandom_range(8, 1)),
                        12'($urandom_range(5, 1)), 16'($urandom));
        if ($urandom_range(3) == 0) queue_write($urandom_range(1) ? REG_SPARE_1 : REG_SPARE_0,
                                                16'($urandom));
      end
      program_registers();
      cols  = (sb.byte_width == 0) ? 4096 : sb.byte_width;
      rows  = (sb.row_count == 0) ? 4096 : sb.row_count;
      walk  = rows * (cols + (sb.in_shift_mode() ? 1 : 0));
      count = walk * $urandom_range(2, 1) + $urandom_range(walk);
      if (count > 160) count = 160;
      repeat (count) begin
        send_byte(8'($urandom_range(255)));
        // now and then let the output run dry mid-rectangle
        if ($urandom_range(63) == 0) hold_for_drain();
      end
      sent += count;
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: right shift by one, one byte wide, one row at address zero.
    send_byte(8'h81); send_byte(8'h7e);
    // Priming byte, then writes to spare indexes: ignored, so the carry must survive.
    send_byte(8'h3c);
    settle();
    queue_write(REG_SPARE_0, 16'hffff);
    queue_write(REG_SPARE_1, 16'h0000);
    program_registers();
    send_byte(8'hc3);

    // Right shift by seven, wrap past the top of memory, most negative pitch.
    settle();
    queue_rectangle(MODE_SHR_ASC, 3'd7, 16'hfffe, 12'd3, 12'd2, 16'h8000);
    program_registers();
    send_byte(8'h00); send_byte(8'hff); send_byte(8'h80); send_byte(8'h01);
    send_byte(8'hff); send_byte(8'h00); send_byte(8'h55); send_byte(8'haa);

    // Left shift with a zero shift amount: back shift of eight, walk down through zero.
    settle();
    queue_rectangle(MODE_SHL_DESC, 3'd0, 16'h0000, 12'd2, 12'd2, 16'h7fff);
    program_registers();
    send_byte(8'hff); send_byte(8'ha5); send_byte(8'h5a);
    send_byte(8'h01); send_byte(8'h80); send_byte(8'hff);

    // Aligned modes ignore the source and fill.
    settle();
    queue_rectangle(MODE_ALIGN_ASC, 3'd3, 16'h1234, 12'd2, 12'd2, 16'hffff);
    program_registers();
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
    settle();
    queue_rectangle(MODE_ALIGN_DESC, 3'd4, 16'h0000, 12'd1, 12'd1, 16'h0000);
    program_registers();
    send_byte(8'h00); send_byte(8'hff);

    // Random part under three idling regimes.
    sender_gap_pct = 32; receiver_gap_pct = 48;
    random_items(400);
    sender_gap_pct = 48; receiver_gap_pct = 32;
    random_items(400);
    sender_gap_pct = 0; receiver_gap_pct = 0;
    random_items(400);

    // Zero width means 4096 bytes per row: no row end may show up early.
    settle();
    queue_rectangle(MODE_ALIGN_ASC, 3'd5, 16'hf000, 12'd0, 12'd1, 16'h0001);
    program_registers();
    repeat (96) send_byte(8'($urandom_range(255)));
    // Largest width and row count; only the start of the walk.
    settle();
    queue_rectangle(MODE_SHR_ASC, 3'd2, 16'hffff, 12'd4095, 12'd4095, 16'h8001);
    program_registers();
    repeat (40) send_byte(8'($urandom_range(255)));
    // Zero rows means 4096 rows: single-byte rows stepping down by one.
    settle();
    queue_rectangle(MODE_SHL_DESC, 3'd6, 16'h0002, 12'd1, 12'd0, 16'hffff);
    program_registers();
    repeat (30) send_byte(8'($urandom_range(255)));

    // Drain, then give stray writes a chance to show up.
    hold_for_drain();
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
